>>> rtl/core/srd_pkg.sv
package srd_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_RAMP = 2'd0,
    REQ_SET  = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  localparam logic [9:0]  MS_LAST        = 10'd999;   // last millisecond of a second
  localparam logic [12:0] SECONDS_MAX    = 13'd8191;
  localparam logic [12:0] TIMEOUT_MAX    = 13'd6000;
  localparam logic [12:0] TIMEOUT_RESET  = 13'd600;
  localparam logic [7:0]  LEVEL_FULL     = 8'd255;
  localparam logic signed [15:0] PERCENT_FULL = 16'sd100;

  // pct*255/100 == (pct*10445) >> 12, exact for pct in 0..100
  localparam logic [13:0] PCT_SCALE_MULT = 14'd10445;
  localparam int          PCT_SCALE_SHIFT = 12;

  // Clamp a signed percent and scale it to a 0..255 level
  function automatic logic [7:0] percent_to_level(input logic signed [15:0] pct);
    logic [20:0] prod;
    prod = 21'(pct[6:0]) * 21'(PCT_SCALE_MULT);
    if (pct[15]) begin
      return 8'd0;
    end else if (pct > PERCENT_FULL) begin
      return LEVEL_FULL;
    end
    return prod[PCT_SCALE_SHIFT +: 8];
  endfunction

  // Gamma duty: level*level/255; x/255 == (x + (x>>8) + 1) >> 8 for x up to 255*255
  function automatic logic [7:0] duty_from_level(input logic [7:0] level);
    logic [15:0] sq;
    logic [16:0] sum;
    sq  = 16'(level) * 16'(level);
    sum = 17'(sq) + 17'(sq[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

>>> rtl/core/soft_ramp_dimmer_with_timeout.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------------
// input    | in_valid / in_stall     | req_type, level_percent
// result   | out_valid / out_stall   | pwm_duty, current_level, target_level,
//          |                         | target_changed
// config   | cfg_wr_en               | cfg_wr_data (timeout_seconds, clamped to 6000)
//
// One transaction per cycle while in_stall is low: state updates and the result register
// load on the accepting edge; the result is presented in the cycle after.
// in_stall is high only while the result register holds a transaction that is stalled.
// Synchronous active-high rst: levels and timer to 0, timeout to 600 seconds.
// Each transaction yields exactly one result transaction.
module soft_ramp_dimmer_with_timeout (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] level_percent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         pwm_duty,
  output logic [7:0]         current_level,
  output logic [7:0]         target_level,
  output logic               target_changed,
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data
);

  logic [12:0] timeout_seconds;
  logic [7:0]  level_now,  level_now_next;
  logic [7:0]  level_goal, level_goal_next;
  logic [9:0]  millis,     millis_next;
  logic [12:0] seconds,    seconds_next;
  logic [7:0]  goal_eff;
  logic        in_acc;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Per-request state update
  always_comb begin
    level_now_next  = level_now;
    level_goal_next = level_goal;
    millis_next     = millis;
    seconds_next    = seconds;
    goal_eff        = level_goal;
    case (req_type)
      srd_pkg::REQ_TICK: begin
        if (millis == srd_pkg::MS_LAST) begin
          millis_next = '0;
          if (seconds != srd_pkg::SECONDS_MAX) begin
            seconds_next = seconds + 13'd1;
          end
        end else begin
          millis_next = millis + 10'd1;
        end
      end
      srd_pkg::REQ_SET: begin
        level_goal_next = srd_pkg::percent_to_level(level_percent);
        millis_next     = '0;
        seconds_next    = '0;
      end
      srd_pkg::REQ_RAMP: begin
        // off-timer expiry forces the target to dark
        if (seconds > timeout_seconds) begin
          goal_eff     = '0;
          millis_next  = '0;
          seconds_next = '0;
        end
        level_goal_next = goal_eff;
        if (level_now < goal_eff) begin
          level_now_next = level_now + 8'd1;
        end else if (level_now > goal_eff) begin
          level_now_next = level_now - 8'd1;
        end
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= srd_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_seconds <= (cfg_wr_data > srd_pkg::TIMEOUT_MAX) ? srd_pkg::TIMEOUT_MAX
                                                              : cfg_wr_data;
    end
  end

  // Block state
  always_ff @(posedge clk) begin
    if (rst) begin
      level_now  <= '0;
      level_goal <= '0;
      millis     <= '0;
      seconds    <= '0;
    end else if (in_acc) begin
      level_now  <= level_now_next;
      level_goal <= level_goal_next;
      millis     <= millis_next;
      seconds    <= seconds_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pwm_duty       <= srd_pkg::duty_from_level(level_now_next);
      current_level  <= level_now_next;
      target_level   <= level_goal_next;
      target_changed <= (level_goal_next != level_goal);
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted transaction produced no result");

  a_duty_le_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pwm_duty <= current_level))
    else $error("duty exceeds level");

  a_timeout_clamped: assert property (@(posedge clk) disable iff (rst)
    timeout_seconds <= srd_pkg::TIMEOUT_MAX)
    else $error("timeout above limit");

  a_level_one_step: assert property (@(posedge clk) disable iff (rst)
    (!rst && in_acc) |=> (level_now == $past(level_now) ||
                          level_now == 8'($past(level_now) + 8'd1) ||
                          level_now == 8'($past(level_now) - 8'd1)))
    else $error("level moved more than one step");

  a_millis_range: assert property (@(posedge clk) disable iff (rst)
    millis <= srd_pkg::MS_LAST)
    else $error("millisecond count out of range");
`endif

endmodule
